/* src/dpf_pkg.sv */
`timescale 1ns / 1ps

package dpf_pkg;

  localparam int SQ_ITERS   = 25;  // result bits of the 48 bit square root
  localparam int SQ_STAGES  = 13;  // two iterations per stage
  localparam int DIV_BITS   = 17;  // quotient bits of |d| * 2^16 / r
  localparam int DIV_STAGES = 9;   // two quotient bits per stage
  localparam int LANES      = 3;

  localparam logic [15:0] REG_REPULSION = 16'd0;
  localparam logic [15:0] REG_DRAG      = 16'd1;
  localparam logic [15:0] REG_NOISE     = 16'd2;
  localparam logic [15:0] REG_CUTOFF    = 16'd3;

  localparam logic [23:0] RST_REPULSION = 24'd1638400;
  localparam logic [23:0] RST_DRAG      = 24'd294912;
  localparam logic [23:0] RST_NOISE     = 24'd196608;
  localparam logic [23:0] RST_CUTOFF    = 24'd65536;

  localparam logic signed [71:0] S32_MAX  = 72'sh0000_7FFF_FFFF;
  localparam logic signed [71:0] S32_MIN  = -72'sh0000_8000_0000;
  localparam logic signed [71:0] DRAG_MAX = 72'sh0F_FFFF_FFFF;

  typedef struct packed {
    logic signed [23:0] dx;
    logic signed [23:0] dy;
    logic signed [23:0] dz;
    logic signed [23:0] dvx;
    logic signed [23:0] dvy;
    logic signed [23:0] dvz;
    logic signed [15:0] noise;
  } pair_t;

  typedef struct packed {
    logic [48:0] x;
    logic [49:0] res;
  } sq_t;

  typedef struct packed {
    logic [40:0] n;
    logic [16:0] q;
  } dv_t;

  // one digit of the bitwise integer square root
  function automatic sq_t sqrt_step(sq_t s, int i);
    logic [49:0] bitv;
    logic [49:0] t;
    sq_t o;
    o = s;
    if (i < SQ_ITERS) begin
      bitv = 50'(1) << (2 * (SQ_ITERS - 1) - 2 * i);
      t = s.res + bitv;
      if ({1'b0, s.x} >= t) begin
        o.x   = 49'({1'b0, s.x} - t);
        o.res = (s.res >> 1) + bitv;
      end else begin
        o.res = s.res >> 1;
      end
    end
    return o;
  endfunction

  // one quotient bit of restoring division
  function automatic dv_t div_step(dv_t s, logic [23:0] r, int j);
    logic [40:0] rs;
    dv_t o;
    o = s;
    if (j >= 0) begin
      rs = 41'(r) << j;
      if (s.n >= rs) begin
        o.n = s.n - rs;
        o.q = s.q | (17'(1) << j);
      end
    end
    return o;
  endfunction

  // floor((v + 2^(n-1)) / 2^n)
  function automatic logic signed [71:0] rnd_sh(logic signed [71:0] v, int n);
    logic signed [71:0] h;
    h = 72'sd1 <<< (n - 1);
    return (v + h) >>> n;
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [71:0] v);
    logic signed [71:0] c;
    c = v;
    if (v > S32_MAX) c = S32_MAX;
    if (v < S32_MIN) c = S32_MIN;
    return c[31:0];
  endfunction

endpackage

/* src/dpd_pair_force.sv */
`timescale 1ns / 1ps
// DPD pair force pipeline (conservative, dissipative and random terms).
// Input channel: in_valid_i / in_stall_o with the pair fields dx..noise_sample.
// Output channel: out_valid_o / out_stall_i with force_x/y/z, pair_virial and
// in_range. An item moves on a rising edge with valid high and stall low.
// There are 36 register stages, the last being the output register; one pair
// is taken every cycle while the pipeline is not held. The depth is set by the
// square root (two digits per stage, 13 stages) and the three normalizing
// dividers (two quotient bits per stage, 9 stages), followed by ten
// multiply/round stages.
// The whole pipeline advances as one; it holds while a result sits in the
// output register and out_stall_i is high, and in_stall_o follows that.
// Reset empties the pipeline and loads the default parameters
// (A 25.0, gamma 4.5, sigma/sqrt(dt) 3.0, cutoff 1.0).
// Registers sit on the APB port at byte addresses 0, 4, 8, 12; pready is
// always high; write them only while the pipeline is empty.
// Pairs with r >= cutoff or r == 0 return zeros with in_range low.
module dpd_pair_force
  import dpf_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [23:0] dx_i,
  input  logic signed [23:0] dy_i,
  input  logic signed [23:0] dz_i,
  input  logic signed [23:0] dvx_i,
  input  logic signed [23:0] dvy_i,
  input  logic signed [23:0] dvz_i,
  input  logic signed [15:0] noise_sample_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] force_x_o,
  output logic signed [31:0] force_y_o,
  output logic signed [31:0] force_z_o,
  output logic signed [31:0] pair_virial_o,
  output logic               in_range_o
);

  localparam int LAT = 3 + SQ_STAGES + 1 + DIV_STAGES + 10;

  logic [23:0] rep_q, drag_q, nsc_q, cut_q;
  logic [15:0] reg_idx;
  logic        en;
  logic [LAT-1:0] vld_q;

  assign reg_idx = 16'(paddr[3:2]);
  assign pready  = 1'b1;

  always_comb begin
    unique case (reg_idx)
      REG_REPULSION: prdata = 32'(rep_q);
      REG_DRAG:      prdata = 32'(drag_q);
      REG_NOISE:     prdata = 32'(nsc_q);
      REG_CUTOFF:    prdata = 32'(cut_q);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rep_q  <= RST_REPULSION;
      drag_q <= RST_DRAG;
      nsc_q  <= RST_NOISE;
      cut_q  <= RST_CUTOFF;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_REPULSION: rep_q  <= pwdata[23:0];
        REG_DRAG:      drag_q <= pwdata[23:0];
        REG_NOISE:     nsc_q  <= pwdata[23:0];
        REG_CUTOFF:    cut_q  <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  assign en          = !(vld_q[LAT-1] && out_stall_i);
  assign in_stall_o  = !en;
  assign out_valid_o = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i};
    end
  end

  // ---- input, squares, r^2 ----
  pair_t       p0_q, p1_q;
  logic [47:0] sqr1_q [LANES];

  always_ff @(posedge clk_i) begin
    if (en) begin
      p0_q <= '{dx: dx_i, dy: dy_i, dz: dz_i, dvx: dvx_i, dvy: dvy_i, dvz: dvz_i,
                noise: noise_sample_i};
      p1_q <= p0_q;
      sqr1_q[0] <= 48'(p0_q.dx * p0_q.dx);
      sqr1_q[1] <= 48'(p0_q.dy * p0_q.dy);
      sqr1_q[2] <= 48'(p0_q.dz * p0_q.dz);
    end
  end

  sq_t   sqs_q [SQ_STAGES+1];
  pair_t sqp_q [SQ_STAGES+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      sqs_q[0].x   <= 49'(sqr1_q[0]) + 49'(sqr1_q[1]) + 49'(sqr1_q[2]);
      sqs_q[0].res <= '0;
      sqp_q[0]     <= p1_q;
    end
  end

  for (genvar k = 1; k <= SQ_STAGES; k++) begin : g_sq
    always_ff @(posedge clk_i) begin
      if (en) begin
        sqs_q[k] <= sqrt_step(sqrt_step(sqs_q[k-1], 2 * k - 2), 2 * k - 1);
        sqp_q[k] <= sqp_q[k-1];
      end
    end
  end

  // ---- range check and unit vector division ----
  logic [23:0] r_root;
  assign r_root = sqs_q[SQ_STAGES].res[23:0];

  dv_t         dvl_q [DIV_STAGES+1][LANES];
  logic [23:0] dvr_q [DIV_STAGES+1];
  logic        dvo_q [DIV_STAGES+1];
  pair_t       dvp_q [DIV_STAGES+1];

  function automatic logic [23:0] mag24(logic signed [23:0] v);
    return v[23] ? 24'(-v) : 24'(v);
  endfunction

  always_ff @(posedge clk_i) begin
    if (en) begin
      dvr_q[0] <= (r_root == '0) ? 24'd1 : r_root;
      dvo_q[0] <= (r_root == '0) || (r_root >= cut_q);
      dvp_q[0] <= sqp_q[SQ_STAGES];
      dvl_q[0][0] <= '{n: {1'b0, mag24(sqp_q[SQ_STAGES].dx), 16'd0}, q: '0};
      dvl_q[0][1] <= '{n: {1'b0, mag24(sqp_q[SQ_STAGES].dy), 16'd0}, q: '0};
      dvl_q[0][2] <= '{n: {1'b0, mag24(sqp_q[SQ_STAGES].dz), 16'd0}, q: '0};
    end
  end

  for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_div
    always_ff @(posedge clk_i) begin
      if (en) begin
        for (int l = 0; l < LANES; l++) begin
          dvl_q[k][l] <= div_step(div_step(dvl_q[k-1][l], dvr_q[k-1],
                                           DIV_BITS - 2 * k + 1),
                                  dvr_q[k-1], DIV_BITS - 2 * k);
        end
        dvr_q[k] <= dvr_q[k-1];
        dvo_q[k] <= dvo_q[k-1];
        dvp_q[k] <= dvp_q[k-1];
      end
    end
  end

  // ---- force arithmetic ----
  pair_t pd;
  logic signed [17:0] e_d [LANES];
  logic signed [25:0] w_d;
  logic signed [23:0] dv_d [LANES];
  logic signed [23:0] d_d [LANES];

  assign pd = dvp_q[DIV_STAGES];
  assign d_d[0] = pd.dx;
  assign d_d[1] = pd.dy;
  assign d_d[2] = pd.dz;
  assign dv_d[0] = pd.dvx;
  assign dv_d[1] = pd.dvy;
  assign dv_d[2] = pd.dvz;
  assign w_d = 26'sd65536 - $signed({2'b00, dvr_q[DIV_STAGES]});

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      e_d[l] = d_d[l][23] ? -$signed({1'b0, dvl_q[DIV_STAGES][l].q})
                          : $signed({1'b0, dvl_q[DIV_STAGES][l].q});
    end
  end

  // a1..a10 stage registers
  logic               oor_q [9];
  pair_t              ap_q  [8];
  logic signed [17:0] e_q   [6][LANES];

  logic signed [41:0] a1_p_q [LANES];
  logic signed [51:0] a1_ww_q;
  logic signed [50:0] a1_aw_q, a1_nw_q;

  logic signed [27:0] edv_q [4];
  logic signed [34:0] a2_w2_q, a2_nws_q;
  logic signed [34:0] fc_q  [4];

  logic signed [59:0] a3_gm_q;
  logic signed [50:0] a3_fr_q;

  logic signed [37:0] a4_g_q;
  logic signed [36:0] fr_q [2];

  logic signed [46:0] a5_lo_q;
  logic signed [47:0] a5_hi_q;

  logic signed [49:0] a6_f_q;
  logic signed [43:0] a7_lo_q [LANES];
  logic signed [42:0] a7_hi_q [LANES];
  logic signed [31:0] a8_f_q  [LANES];
  logic signed [31:0] a9_f_q  [LANES];
  logic signed [55:0] a9_v_q  [LANES];

  logic signed [71:0] gedv_w, fd_w, vir_w;

  assign gedv_w = (72'(a5_hi_q) <<< 18) + 72'(a5_lo_q);
  assign fd_w   = -rnd_sh(gedv_w, 16);
  assign vir_w  = rnd_sh(72'(a9_v_q[0]) + 72'(a9_v_q[1]) + 72'(a9_v_q[2]), 16);

  always_ff @(posedge clk_i) begin
    if (en) begin
      // a1: products
      oor_q[0] <= dvo_q[DIV_STAGES];
      ap_q[0]  <= pd;
      for (int l = 0; l < LANES; l++) begin
        e_q[0][l]  <= e_d[l];
        a1_p_q[l]  <= 42'(e_d[l] * dv_d[l]);
      end
      a1_ww_q <= 52'(w_d * w_d);
      a1_aw_q <= 51'($signed({1'b0, rep_q}) * w_d);
      a1_nw_q <= 51'($signed({1'b0, nsc_q}) * w_d);

      for (int s = 1; s < 9; s++) begin
        oor_q[s] <= oor_q[s-1];
      end
      for (int s = 1; s < 8; s++) begin
        ap_q[s] <= ap_q[s-1];
      end
      for (int s = 1; s < 6; s++) begin
        e_q[s] <= e_q[s-1];
      end

      // a2: rounding
      edv_q[0] <= 28'(rnd_sh(72'(a1_p_q[0]) + 72'(a1_p_q[1]) + 72'(a1_p_q[2]), 16));
      a2_w2_q  <= 35'(rnd_sh(72'(a1_ww_q), 16));
      fc_q[0]  <= 35'(rnd_sh(72'(a1_aw_q), 16));
      a2_nws_q <= 35'(rnd_sh(72'(a1_nw_q), 16));

      // a3: drag gain and noise products
      a3_gm_q  <= 60'($signed({1'b0, drag_q}) * a2_w2_q);
      a3_fr_q  <= 51'(a2_nws_q * ap_q[1].noise);
      edv_q[1] <= edv_q[0];
      fc_q[1]  <= fc_q[0];

      // a4: round, clamp the gain
      begin
        logic signed [71:0] g;
        g = rnd_sh(72'(a3_gm_q), 16);
        if (g > DRAG_MAX) g = DRAG_MAX;
        if (g < 0) g = '0;
        a4_g_q <= 38'(g);
      end
      fr_q[0]  <= 37'(rnd_sh(72'(a3_fr_q), 14));
      edv_q[2] <= edv_q[1];
      fc_q[2]  <= fc_q[1];

      // a5: gain times e.dv in two partial products
      a5_lo_q <= 47'($signed({1'b0, a4_g_q[17:0]}) * edv_q[2]);
      a5_hi_q <= 48'($signed(a4_g_q[37:18]) * edv_q[2]);
      fr_q[1] <= fr_q[0];
      fc_q[3] <= fc_q[2];

      // a6: scalar force
      a6_f_q <= 50'(72'(fc_q[3]) + fd_w + 72'(fr_q[1]));

      // a7: force along e in two partial products per lane
      for (int l = 0; l < LANES; l++) begin
        a7_lo_q[l] <= 44'($signed({1'b0, a6_f_q[24:0]}) * e_q[5][l]);
        a7_hi_q[l] <= 43'($signed(a6_f_q[49:25]) * e_q[5][l]);
      end

      // a8: force components
      for (int l = 0; l < LANES; l++) begin
        a8_f_q[l] <= sat32(rnd_sh((72'(a7_hi_q[l]) <<< 25) + 72'(a7_lo_q[l]), 16));
      end

      // a9: virial products
      a9_f_q <= a8_f_q;
      a9_v_q[0] <= 56'(a8_f_q[0] * ap_q[7].dx);
      a9_v_q[1] <= 56'(a8_f_q[1] * ap_q[7].dy);
      a9_v_q[2] <= 56'(a8_f_q[2] * ap_q[7].dz);

      // a10: output register
      force_x_o     <= oor_q[8] ? '0 : a9_f_q[0];
      force_y_o     <= oor_q[8] ? '0 : a9_f_q[1];
      force_z_o     <= oor_q[8] ? '0 : a9_f_q[2];
      pair_virial_o <= oor_q[8] ? '0 : sat32(vir_w);
      in_range_o    <= !oor_q[8];
    end
  end

endmodule

/* verif/tb_dpd_pair_force.sv */
`timescale 1ns / 1ps

module tb_dpd_pair_force;
  import dpf_pkg::*;

  typedef struct packed {
    logic signed [31:0] fx;
    logic signed [31:0] fy;
    logic signed [31:0] fz;
    logic signed [31:0] vir;
    logic               hit;
  } force_t;

  typedef struct packed {
    pair_t  p;
    logic   typed;
    force_t res;
  } row_t;

  localparam force_t NO_FORCE = '0;
  localparam int     WD_LIMIT = 5000;
  localparam int     SEG_ITEMS = 85;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [23:0] dx_i = '0, dy_i = '0, dz_i = '0;
  logic signed [23:0] dvx_i = '0, dvy_i = '0, dvz_i = '0;
  logic signed [15:0] noise_sample_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [31:0] force_x_o, force_y_o, force_z_o, pair_virial_o;
  logic in_range_o;

  dpd_pair_force DUT (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // local copy of the parameter registers
  logic [23:0] amp = RST_REPULSION, gam = RST_DRAG, sig = RST_NOISE, cut = RST_CUTOFF;

  force_t force_q[$];
  int tx_idle = 0, rx_idle = 0;
  int n_sent = 0, n_got = 0, n_hit = 0, n_fail = 0, quiet = 0;

  function automatic longint rnd(longint v, int n);
    return (v + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic force_t pair_force(pair_t p);
    longint d[3], dv[3], e[3], f[3];
    longint x, res, bitv, r, w, fc, edv, w2, g, fd, fr, fsum, vir;
    force_t o;
    d[0] = p.dx;  d[1] = p.dy;  d[2] = p.dz;
    dv[0] = p.dvx; dv[1] = p.dvy; dv[2] = p.dvz;
    x = d[0] * d[0] + d[1] * d[1] + d[2] * d[2];
    res = 0;
    bitv = 64'sd1 <<< 48;
    while (bitv > x) bitv = bitv >>> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >>> 1) + bitv;
      end else begin
        res = res >>> 1;
      end
      bitv = bitv >>> 2;
    end
    r = res;
    if (r == 0 || r >= longint'(cut)) return NO_FORCE;
    w = 65536 - r;
    for (int k = 0; k < 3; k++) e[k] = (d[k] * 65536) / r;
    fc = rnd(longint'(amp) * w, 16);
    edv = rnd(e[0] * dv[0] + e[1] * dv[1] + e[2] * dv[2], 16);
    w2 = rnd(w * w, 16);
    g = rnd(longint'(gam) * w2, 16);
    if (g < 0) g = 0;
    if (g > (64'sd1 <<< 36) - 1) g = (64'sd1 <<< 36) - 1;
    fd = -rnd(g * edv, 16);
    fr = rnd(rnd(longint'(sig) * w, 16) * longint'(p.noise), 14);
    fsum = fc + fd + fr;
    vir = 0;
    for (int k = 0; k < 3; k++) begin
      f[k] = clip32(rnd(fsum * e[k], 16));
      vir += f[k] * d[k];
    end
    vir = clip32(rnd(vir, 16));
    o.fx = f[0][31:0];
    o.fy = f[1][31:0];
    o.fz = f[2][31:0];
    o.vir = vir[31:0];
    o.hit = 1'b1;
    return o;
  endfunction

  function automatic logic signed [23:0] rand_coord(int lim);
    if ($urandom_range(99) < 8) return 24'($urandom);
    return 24'($urandom_range(0, 2 * lim) - lim);
  endfunction

  function automatic pair_t rand_pair();
    pair_t p;
    int lim;
    lim = (cut >> 1) > 8388607 ? 8388607 : int'(cut >> 1);
    if (lim < 1) lim = 1;
    p.dx = rand_coord(lim);
    p.dy = rand_coord(lim);
    p.dz = rand_coord(lim);
    p.dvx = 24'($urandom);
    p.dvy = ($urandom_range(1)) ? 24'($urandom) : 24'($urandom_range(0, 200000) - 100000);
    p.dvz = 24'($urandom);
    p.noise = ($urandom_range(99) < 85) ? 16'($urandom_range(0, 56756) - 28378)
                                        : 16'($urandom);
    return p;
  endfunction

  task automatic send_item(input pair_t p, input logic typed, input force_t res);
    while ($urandom_range(99) < tx_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    {dx_i, dy_i, dz_i, dvx_i, dvy_i, dvz_i, noise_sample_i} <= p;
    do @(posedge clk_i); while (in_stall_o);
    force_q.insert(force_q.size(), typed ? res : pair_force(p));
    n_sent++;
  endtask

  // pipeline is flushed: wait for every pending result, then idle with in_valid_i low
  task automatic drain();
    in_valid_i <= 1'b0;
    while (force_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic reg_write(input logic [15:0] idx, input logic [23:0] v);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= 4'(idx * 4);
    pwdata <= {8'h00, v};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    unique case (idx)
      REG_REPULSION: amp = v;
      REG_DRAG:      gam = v;
      REG_NOISE:     sig = v;
      REG_CUTOFF:    cut = v;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_params(input logic [23:0] a, g, s, c);
    drain();
    reg_write(REG_REPULSION, a);
    reg_write(REG_DRAG, g);
    reg_write(REG_NOISE, s);
    reg_write(REG_CUTOFF, c);
  endtask

  task automatic chk(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      n_fail++;
    end
  endtask

  // result checker and receiver stall
  always @(posedge clk_i) begin
    force_t want;
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet <= 0;
      else quiet <= quiet + 1;
      if (out_valid_o && !out_stall_i) begin
        n_got++;
        if (force_q.size() == 0) begin
          $error("result with no item pending");
          n_fail++;
        end else begin
          want = force_q.pop_front();
          if (want.hit) n_hit++;
          chk("force_x", want.fx, force_x_o);
          chk("force_y", want.fy, force_y_o);
          chk("force_z", want.fz, force_z_o);
          chk("pair_virial", want.vir, pair_virial_o);
          chk("in_range", want.hit, in_range_o);
        end
      end
      out_stall_i <= ($urandom_range(99) < rx_idle);
      if (quiet >= WD_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", WD_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  row_t rows[] = '{
    '{pair_t'{24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 16'sd0}, 1'b1, NO_FORCE},
    '{pair_t'{24'sd65536, 24'sd0, 24'sd0, 24'sd5, 24'sd0, 24'sd0, 16'sd100}, 1'b1, NO_FORCE},
    '{pair_t'{-24'sd8388608, -24'sd8388608, -24'sd8388608, -24'sd8388608, -24'sd8388608,
              -24'sd8388608, -16'sd28378}, 1'b1, NO_FORCE},
    '{pair_t'{24'sd8388607, 24'sd8388607, 24'sd8388607, 24'sd8388607, 24'sd8388607,
              24'sd8388607, 16'sd28378}, 1'b1, NO_FORCE},
    '{pair_t'{24'sd32768, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 16'sd0}, 1'b0, NO_FORCE},
    '{pair_t'{-24'sd32768, 24'sd16384, 24'sd8192, 24'sd8388607, -24'sd8388608, 24'sd100,
              16'sd28378}, 1'b0, NO_FORCE},
    '{pair_t'{-24'sd32768, 24'sd16384, 24'sd8192, 24'sd1000, -24'sd70000, 24'sd0,
              -16'sd28378}, 1'b0, NO_FORCE},
    '{pair_t'{24'sd20000, -24'sd20000, 24'sd300, 24'sd0, 24'sd0, 24'sd0, -16'sd32768},
      1'b0, NO_FORCE},
    '{pair_t'{24'sd20000, -24'sd20000, 24'sd300, 24'sd0, 24'sd0, 24'sd0, 16'sd32767},
      1'b0, NO_FORCE},
    '{pair_t'{24'sd1, 24'sd0, 24'sd0, -24'sd8388608, 24'sd0, 24'sd0, 16'sd16384}, 1'b0,
      NO_FORCE},
    '{pair_t'{24'sd65535, 24'sd0, 24'sd0, 24'sd8388607, 24'sd0, 24'sd0, 16'sd28378}, 1'b0,
      NO_FORCE},
    '{pair_t'{24'sd0, -24'sd65535, 24'sd0, 24'sd0, -24'sd8388608, 24'sd0, -16'sd28378}, 1'b0,
      NO_FORCE},
    '{pair_t'{24'sd0, 24'sd0, 24'sd40000, 24'sd0, 24'sd0, 24'sd8388607, 16'sd28378}, 1'b0,
      NO_FORCE}
  };

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tx_idle = 10;
    rx_idle = 64;
    foreach (rows[i]) send_item(rows[i].p, rows[i].typed, rows[i].res);

    // six segments: defaults, extremes, random, zero gains, random, small cutoff
    for (int s = 0; s < 6; s++) begin
      tx_idle = (s < 2) ? 10 : (s < 4) ? 64 : 0;
      rx_idle = (s < 2) ? 64 : (s < 4) ? 10 : 0;
      unique case (s)
        0: ;
        1: set_params(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        2: set_params(24'($urandom), 24'($urandom_range(0, 2000000)),
                      24'($urandom), 24'($urandom_range(16384, 300000)));
        3: set_params('0, '0, '0, 24'($urandom_range(30000, 200000)));
        4: set_params(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom));
        default: set_params(RST_REPULSION, RST_DRAG, RST_NOISE, 24'd2);
      endcase
      for (int i = 0; i < SEG_ITEMS; i++) send_item(rand_pair(), 1'b0, NO_FORCE);
    end

    // a cutoff of zero leaves every pair out of range
    set_params(RST_REPULSION, RST_DRAG, RST_NOISE, '0);
    for (int i = 0; i < 10; i++) send_item(rand_pair(), 1'b0, NO_FORCE);
    drain();

    $display("%0d pairs sent, %0d results checked, %0d inside cutoff, over 7 parameter sets",
             n_sent, n_got, n_hit);
    $display("idle patterns: sender-light, receiver-light and back-to-back");
    if (n_fail == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
